// ===== rtl/core/rswr_pkg.sv =====
// Shared types, widths and constants of the random sample without replacement core.
package rswr_pkg;

    // Field widths fixed by the stream and register layout
    localparam int IDX_W      = 9;     // candidate index / excluded index / chosen index
    localparam int CNT_W      = 10;    // population size, candidate total, pick position
    localparam int LIMIT_W    = 9;     // pick limit register
    localparam int RNG_W      = 32;    // generator state
    localparam int STEP_W     = $clog2(RNG_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam int MAX_CELLS_DEF = 512;

    localparam logic [RNG_W-1:0]   DEFAULT_SEED = 32'h1d87_2b41;
    localparam logic [RNG_W-1:0]   ALL_ONES     = 32'hffff_ffff;
    localparam logic [CNT_W-1:0]   CELL_COUNT_RST = 10'd81;
    localparam logic [LIMIT_W-1:0] PICK_LIMIT_RST = 9'd10;

    // Register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_LIMIT = 2'd2;

    // Operation codes carried on s_tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_LIM_WAIT,
        ST_GEN,
        ST_CHECK,
        ST_MOD_WAIT,
        ST_READ,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_EMIT
    } rswr_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic fill_step;
        logic fill_finish;
        logic mark_exh;
        logic lim_start;
        logic lim_load;
        logic gen_step;
        logic val_start;
        logic pick_load;
        logic rd_issue;
        logic wr_pick;
        logic wr_pos;
        logic res_load;
    } rswr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op;
        logic exhausted;
        logic fill_end;
        logic div_done;
        logic val_ok;
        logic out_free;
    } rswr_stat_t;

endpackage

// ===== rtl/core/rswr_mod_unit.sv =====
// Bit-serial restoring remainder unit: 32-bit dividend modulo a narrow divisor.
module rswr_mod_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rswr_pkg::RNG_W-1:0] dividend,
    input  logic [rswr_pkg::CNT_W-1:0] divisor,
    output logic [rswr_pkg::CNT_W-1:0] remainder,
    output logic                       done
);
    import rswr_pkg::*;

    logic [RNG_W-1:0]  dvd_reg;
    logic [RNG_W-1:0]  dvd_next;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  div_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W:0]    trial;

    // One quotient bit per cycle; remainder stays below the divisor
    assign trial = {rem_reg, dvd_reg[RNG_W-1]};

    always_comb
    begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[RNG_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(RNG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== rtl/core/rswr_datapath.sv =====
// Datapath: registers, generator, candidate memory, remainder unit and result register.
module rswr_datapath #(
    parameter int MAX_CELLS = rswr_pkg::MAX_CELLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rswr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rswr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [rswr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rswr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser,
    input  rswr_pkg::rswr_cmd_t             cmd,
    output rswr_pkg::rswr_stat_t            stat
);
    import rswr_pkg::*;

    localparam int ADDR_W = $clog2(MAX_CELLS);

    logic [IDX_W-1:0]   store_mem [MAX_CELLS];

    logic [CNT_W-1:0]   cell_count_reg;
    logic [LIMIT_W-1:0] pick_limit_reg;
    logic [RNG_W-1:0]   rng_reg;
    logic [RNG_W-1:0]   rng_step;
    logic [RNG_W-1:0]   lim_reg;
    logic               op_reg;
    logic [IDX_W-1:0]   excl_reg;
    logic [CNT_W-1:0]   fill_i_reg;
    logic [CNT_W-1:0]   fill_n_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   pick_reg;
    logic [IDX_W-1:0]   rd_pick_reg;
    logic [IDX_W-1:0]   rd_pos_reg;
    logic [IDX_W-1:0]   chosen_reg;
    logic               exh_reg;
    logic               m_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_exh_reg;

    logic [CNT_W-1:0]   fill_lim;
    logic [CNT_W-1:0]   draw_lim;
    logic               fill_keep;
    logic               div_start;
    logic [RNG_W-1:0]   div_dividend;
    logic [CNT_W-1:0]   div_rem;
    logic               div_done;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [IDX_W-1:0]   wr_data;

    // Population saturates at the memory depth
    assign fill_lim  = (int'(cell_count_reg) > MAX_CELLS) ? CNT_W'(MAX_CELLS) : cell_count_reg;
    assign fill_keep = (fill_i_reg != CNT_W'(excl_reg));
    assign draw_lim  = (CNT_W'(pick_limit_reg) < total_reg) ? CNT_W'(pick_limit_reg)
                                                             : total_reg;

    assign rng_step = (rng_reg ^ (rng_reg << 13)) ^ ((rng_reg ^ (rng_reg << 13)) >> 17);

    // Configuration registers and generator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg <= CELL_COUNT_RST;
            pick_limit_reg <= PICK_LIMIT_RST;
            rng_reg        <= DEFAULT_SEED;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_SEED)
            begin
                rng_reg <= (cfg_data == '0) ? DEFAULT_SEED : cfg_data[RNG_W-1:0];
            end
            else if (cmd.gen_step)
            begin
                rng_reg <= rng_step ^ (rng_step << 5);
            end
            if (cfg_we && cfg_index == REG_CELL_COUNT)
            begin
                cell_count_reg <= cfg_data[CNT_W-1:0];
            end
            if (cfg_we && cfg_index == REG_PICK_LIMIT)
            begin
                pick_limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    // Selection state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            pos_reg     <= '0;
            fill_i_reg  <= '0;
            fill_n_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                fill_i_reg <= '0;
                fill_n_reg <= '0;
            end
            else if (cmd.fill_step)
            begin
                fill_i_reg <= fill_i_reg + 1'b1;
                if (fill_keep)
                begin
                    fill_n_reg <= fill_n_reg + 1'b1;
                end
            end
            if (cmd.fill_finish)
            begin
                total_reg <= fill_n_reg;
                pos_reg   <= '0;
            end
            else if (cmd.wr_pos)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (cmd.res_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= s_tuser;
            excl_reg <= s_tdata[IDX_W-1:0];
        end
        if (cmd.lim_load)
        begin
            lim_reg <= ALL_ONES - RNG_W'(div_rem);
        end
        if (cmd.pick_load)
        begin
            pick_reg <= pos_reg + div_rem;
        end
        if (cmd.mark_exh)
        begin
            chosen_reg <= '0;
            exh_reg    <= 1'b1;
        end
        else if (cmd.wr_pick)
        begin
            chosen_reg <= rd_pick_reg;
            exh_reg    <= 1'b0;
        end
        if (cmd.res_load)
        begin
            out_idx_reg <= chosen_reg;
            out_exh_reg <= exh_reg;
        end
    end

    // Candidate memory: one write port, two registered read ports
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(fill_n_reg);
        wr_data = IDX_W'(fill_i_reg);
        if (cmd.fill_step)
        begin
            wr_en = fill_keep;
        end
        else if (cmd.wr_pick)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(pick_reg);
            wr_data = rd_pos_reg;
        end
        else if (cmd.wr_pos)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(pos_reg);
            wr_data = chosen_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue)
        begin
            rd_pick_reg <= store_mem[ADDR_W'(pick_reg)];
            rd_pos_reg  <= store_mem[ADDR_W'(pos_reg)];
        end
    end

    assign div_start    = cmd.lim_start | cmd.val_start;
    assign div_dividend = cmd.lim_start ? ALL_ONES : rng_reg;

    rswr_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (total_reg - pos_reg),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign stat.op        = op_reg;
    assign stat.exhausted = (pos_reg >= draw_lim);
    assign stat.fill_end  = (fill_i_reg == fill_lim);
    assign stat.div_done  = div_done;
    assign stat.val_ok    = (rng_reg < lim_reg);
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_idx_reg);
    assign m_tuser  = out_exh_reg;

`ifndef NO_ASSERTIONS
    a_pos_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= total_reg)
        else $error("pick position ran past candidate total");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick_load |=> (pick_reg >= pos_reg) && (pick_reg < total_reg))
        else $error("pick outside remaining candidates");

    a_rng_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rng_reg != '0)
        else $error("generator state reached zero");

    a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("exhausted result carries an index");
`endif

endmodule

// ===== rtl/core/rswr_ctrl.sv =====
// Controller state machine sequencing start fills and draw picks.
module rswr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  rswr_pkg::rswr_stat_t stat,
    output rswr_pkg::rswr_cmd_t  cmd
);
    import rswr_pkg::*;

    rswr_state_t state_reg;
    rswr_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.op == OP_START)
                begin
                    state_next = ST_FILL;
                end
                else if (stat.exhausted)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_LIM_WAIT;
                end
            end
            ST_FILL:
            begin
                if (stat.fill_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIM_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_GEN;
                end
            end
            ST_GEN:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = stat.val_ok ? ST_MOD_WAIT : ST_GEN;
            end
            ST_MOD_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SWAP_A;
            end
            ST_SWAP_A:
            begin
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_DECODE:
            begin
                cmd.mark_exh  = (stat.op == OP_DRAW) && stat.exhausted;
                cmd.lim_start = (stat.op == OP_DRAW) && !stat.exhausted;
            end
            ST_FILL:
            begin
                cmd.fill_step   = !stat.fill_end;
                cmd.fill_finish = stat.fill_end;
            end
            ST_LIM_WAIT:
            begin
                cmd.lim_load = stat.div_done;
            end
            ST_GEN:
            begin
                cmd.gen_step = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.val_start = stat.val_ok;
            end
            ST_MOD_WAIT:
            begin
                cmd.pick_load = stat.div_done;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_SWAP_A:
            begin
                cmd.wr_pick = 1'b1;
            end
            ST_SWAP_B:
            begin
                cmd.wr_pos = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.res_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/random_sample_without_replacement_core.sv =====
// Top level of the random sample without replacement core.
//
//  channel  direction  contents (lowest bit first)
//  -------  ---------  ------------------------------------------------------
//  s_*      in         tdata: excluded_index[8:0], zero pad; tuser: op
//  m_*      out        tdata: chosen_index[8:0], zero pad; tuser: exhausted
//  cfg_*    in         write-only: 0 seed, 1 cell_count, 2 pick_limit
//
// A start transaction covers min(cell_count, MAX_CELLS) candidates: the fill walks the
// candidate memory one entry per cycle through its single write port.
// A draw runs the shared bit-serial remainder unit twice, once for the rejection cut
// and once for the pick; each extra generator try costs one generator step and one
// compare. An exhausted draw skips the remainder unit and goes straight to its emit step.
// A finished result sits in the output register while the next transaction is taken in;
// a stalled m_tready only holds the block in its emit step.
// Reset clears the control state and loads the generator with the default seed; the
// candidate memory needs no clearing, since draws only read entries the last start wrote.
module random_sample_without_replacement_core #(
    parameter int MAX_CELLS = rswr_pkg::MAX_CELLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [rswr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rswr_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rswr_pkg::S_TDATA_W-1:0]  s_tdata,   // excluded_index[8:0], pad
    input  logic                            s_tuser,   // op
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rswr_pkg::M_TDATA_W-1:0]  m_tdata,   // chosen_index[8:0], pad
    output logic                            m_tuser    // exhausted
);
    import rswr_pkg::*;

    rswr_cmd_t  cmd;
    rswr_stat_t stat;

    // Sequence fills, rejection tries and the swap
    rswr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold registers, generator, candidate memory and the result register
    rswr_datapath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
